@@ sv/lfid_pkg.sv @@
`default_nettype none
package lfid_pkg;

  localparam int ID_COUNT  = 8192;
  localparam int ID_W      = 16;
  localparam int WORD_W    = 64;
  localparam int BIT_W     = 6;
  localparam int MAP_WORDS = (ID_COUNT + WORD_W - 1) / WORD_W;
  localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int OFF_W     = WIDX_W + BIT_W;
  localparam int SIZE_W    = $clog2(ID_COUNT + 1);
  localparam int CMP_W     = (SIZE_W > ID_W) ? SIZE_W : ID_W;

  localparam logic [ID_W-1:0] BASE_RESET = 16'd300;
  localparam logic [ID_W-1:0] LAST_RESET = 16'd5000;

  typedef enum logic {
    CFG_BASE_ID = 1'b0,
    CFG_LAST_ID = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARD,
    S_ACHK,
    S_RRD,
    S_RWR
  } state_e;

  typedef struct packed {
    logic              found;
    logic [BIT_W-1:0]  idx;
    logic [WORD_W-1:0] onehot;
  } ffs_t;

endpackage
`default_nettype wire

@@ sv/lfid_ffs.sv @@
`default_nettype none
module lfid_ffs (
  input  wire logic [lfid_pkg::WORD_W-1:0] free_i,
  output lfid_pkg::ffs_t                   ffs_o
);

  logic [lfid_pkg::WORD_W-1:0] lowbit;

  assign lowbit = free_i & (~free_i + lfid_pkg::WORD_W'(1));

  always_comb begin
    ffs_o.found  = |free_i;
    ffs_o.onehot = lowbit;
    ffs_o.idx    = '0;
    for (int b = 0; b < lfid_pkg::WORD_W; b++) begin
      if (lowbit[b]) begin
        ffs_o.idx = ffs_o.idx | lfid_pkg::BIT_W'(b);
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/lowest_free_id_allocator.sv @@
`default_nettype none
// Lowest free ID allocator.
// Command channel: start_i with command_i and id_value_i is taken at a rising
// edge where busy_o is low. Allocate (CMD_ALLOC) returns the lowest free ID in
// [base_id, last_id] on granted_id_o, or full_res_o with a zero ID, marked by
// valid_o for exactly one cycle. Release (CMD_RELEASE) frees id_value_i and
// gives no result; out-of-window or already free IDs are ignored.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i (0 base_id,
// 1 last_id); write only while busy_o is low and no result is pending.
// Scan: an allocate scans the used bitmap one 64-bit word per cycle through
// a single read port, reading the next word while it checks the current one;
// the result is registered when the scan finds a free bit or runs out. The
// next item can be taken at the edge that ends the result cycle.
// The window is capped at 8192 IDs (128 words) from base_id.
// A release reads, modifies and writes back a word; a dropped one stays idle.
// One item is in flight at a time; busy_o stays high until it finishes.
// Reset: every ID is free (per-word valid bits cleared at once, no sweep),
// base_id = 300, last_id = 5000. The receiver cannot stall results.
module lowest_free_id_allocator (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  output logic                           busy_o,
  input  wire logic                      command_i,
  input  wire logic [lfid_pkg::ID_W-1:0] id_value_i,
  output logic                           valid_o,
  output logic [lfid_pkg::ID_W-1:0]      granted_id_o,
  output logic                           full_res_o,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_idx_i,
  input  wire logic [lfid_pkg::ID_W-1:0] cfg_wdata_i
);

  lfid_pkg::state_e state_q, state_d;

  logic [lfid_pkg::ID_W-1:0]   base_q, last_q;
  logic [lfid_pkg::SIZE_W-1:0] size_q, size_d;
  logic [lfid_pkg::WIDX_W-1:0] w_q, w_d, cw_q, cw_d;
  logic [lfid_pkg::OFF_W-1:0]  roff_q, roff_d;
  logic                        valid_q, valid_d, full_q, full_d;
  logic [lfid_pkg::ID_W-1:0]   gid_q, gid_d;

  logic [lfid_pkg::WORD_W-1:0] mem [lfid_pkg::MAP_WORDS];
  logic [lfid_pkg::MAP_WORDS-1:0] vld_q;
  logic                        rvld_q;
  logic [lfid_pkg::WORD_W-1:0] rdata_q, word;
  logic [lfid_pkg::WIDX_W-1:0] raddr, waddr;
  logic [lfid_pkg::WORD_W-1:0] wdata;
  logic                        we;

  logic [lfid_pkg::ID_W-1:0]   span, roff_full;
  logic [lfid_pkg::CMP_W-1:0]  span_c, first_c, size_c, rem_c;
  logic                        past_end;
  logic [lfid_pkg::WORD_W-1:0] mask, free_bits;
  lfid_pkg::ffs_t              ffs;

  // window size from current registers
  always_comb begin
    span   = last_q - base_q;
    span_c = lfid_pkg::CMP_W'(span);
    if (last_q < base_q) begin
      size_d = '0;
    end else if (span_c >= lfid_pkg::CMP_W'(lfid_pkg::ID_COUNT)) begin
      size_d = lfid_pkg::SIZE_W'(lfid_pkg::ID_COUNT);
    end else begin
      size_d = lfid_pkg::SIZE_W'(span_c + lfid_pkg::CMP_W'(1));
    end
  end

  assign word      = rvld_q ? rdata_q : '0;
  assign first_c   = lfid_pkg::CMP_W'({cw_q, {lfid_pkg::BIT_W{1'b0}}});
  assign size_c    = lfid_pkg::CMP_W'(size_q);
  assign past_end  = first_c >= size_c;
  assign rem_c     = size_c - first_c;
  assign mask      = (rem_c >= lfid_pkg::CMP_W'(lfid_pkg::WORD_W)) ? '1 :
                     ~({lfid_pkg::WORD_W{1'b1}} << rem_c[lfid_pkg::BIT_W-1:0]);
  assign free_bits = ~word & mask;
  assign roff_full = id_value_i - base_q;

  lfid_ffs u_ffs (
    .free_i (free_bits),
    .ffs_o  (ffs)
  );

  always_comb begin
    state_d = state_q;
    w_d     = w_q;
    cw_d    = cw_q;
    roff_d  = roff_q;
    valid_d = 1'b0;
    full_d  = full_q;
    gid_d   = gid_q;
    raddr   = w_q;
    waddr   = cw_q;
    wdata   = word | ffs.onehot;
    we      = 1'b0;
    unique case (state_q)
      lfid_pkg::S_IDLE: begin
        if (start_i) begin
          if (command_i == lfid_pkg::CMD_ALLOC) begin
            state_d = lfid_pkg::S_ARD;
            w_d     = '0;
          end else if (id_value_i >= base_q &&
                       lfid_pkg::CMP_W'(roff_full) < lfid_pkg::CMP_W'(size_d)) begin
            state_d = lfid_pkg::S_RRD;
            roff_d  = roff_full[lfid_pkg::OFF_W-1:0];
          end
        end
      end
      lfid_pkg::S_ARD: begin
        raddr   = '0;
        cw_d    = '0;
        w_d     = lfid_pkg::WIDX_W'(1);
        state_d = lfid_pkg::S_ACHK;
      end
      lfid_pkg::S_ACHK: begin
        if (past_end ||
            (!ffs.found && cw_q == lfid_pkg::WIDX_W'(lfid_pkg::MAP_WORDS - 1))) begin
          valid_d = 1'b1;
          full_d  = 1'b1;
          gid_d   = '0;
          state_d = lfid_pkg::S_IDLE;
        end else if (ffs.found) begin
          we      = 1'b1;
          valid_d = 1'b1;
          full_d  = 1'b0;
          gid_d   = base_q + lfid_pkg::ID_W'({cw_q, ffs.idx});
          state_d = lfid_pkg::S_IDLE;
        end else begin
          cw_d = w_q;
          w_d  = w_q + lfid_pkg::WIDX_W'(1);
        end
      end
      lfid_pkg::S_RRD: begin
        raddr   = roff_q[lfid_pkg::OFF_W-1:lfid_pkg::BIT_W];
        state_d = lfid_pkg::S_RWR;
      end
      lfid_pkg::S_RWR: begin
        we      = 1'b1;
        waddr   = roff_q[lfid_pkg::OFF_W-1:lfid_pkg::BIT_W];
        wdata   = word & ~(lfid_pkg::WORD_W'(1) << roff_q[lfid_pkg::BIT_W-1:0]);
        state_d = lfid_pkg::S_IDLE;
      end
      default: begin
        state_d = lfid_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lfid_pkg::S_IDLE;
      base_q  <= lfid_pkg::BASE_RESET;
      last_q  <= lfid_pkg::LAST_RESET;
      size_q  <= '0;
      w_q     <= '0;
      cw_q    <= '0;
      roff_q  <= '0;
      valid_q <= 1'b0;
      full_q  <= 1'b0;
      gid_q   <= '0;
      vld_q   <= '0;
      rvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      w_q     <= w_d;
      cw_q    <= cw_d;
      roff_q  <= roff_d;
      valid_q <= valid_d;
      full_q  <= full_d;
      gid_q   <= gid_d;
      rvld_q  <= vld_q[raddr];
      if (state_q == lfid_pkg::S_IDLE && start_i) begin
        size_q <= size_d;
      end
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          lfid_pkg::CFG_BASE_ID: base_q <= cfg_wdata_i;
          lfid_pkg::CFG_LAST_ID: last_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assign busy_o       = (state_q != lfid_pkg::S_IDLE);
  assign valid_o      = valid_q;
  assign granted_id_o = gid_q;
  assign full_res_o   = full_q;

`ifndef ASSERT_OFF
  a_result_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(state_q == lfid_pkg::S_ACHK))
    else $error("result without a finished scan");

  a_full_zero_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && full_q) |-> (gid_q == '0))
    else $error("full result carries a nonzero id");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == lfid_pkg::S_ACHK || state_q == lfid_pkg::S_RWR))
    else $error("bitmap write outside a write state");

  a_readahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lfid_pkg::S_ACHK) |-> (w_q == cw_q + lfid_pkg::WIDX_W'(1)))
    else $error("scan read-ahead out of step");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> !valid_q)
    else $error("two results in consecutive cycles");
`endif

endmodule
`default_nettype wire
